// File: rtl/rmf_pkg.sv
// Shared types and constants for the RGB median filter.
package rmf_pkg;

  localparam int PIX_W = 8;
  localparam int CH_N  = 3;
  localparam int CFG_W = 11;
  localparam int CFG_AW = 2;

  localparam logic [CFG_AW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0]       RADIUS_RST = 2'd1;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DEC,
    S_MODW,
    S_WR,
    S_WSET,
    S_ROW,
    S_MODR,
    S_RD,
    S_WAIT,
    S_MSET,
    S_MED,
    S_OUT
  } state_t;

endpackage

// File: rtl/rgb_median_filter_unit.sv
// Top level of the RGB median filter: line store, window gather and bit-serial median.
//
// Each request takes a variable number of cycles. A pixel that completes no output passes
// through the iterative modulo unit that folds the raster index onto the line store. A
// request that yields an output adds, for each window row, an address step, the modulo
// pass and one read per window pixel (one line-store read port), then the radix-select
// median of all three channels, one bit plane per cycle, and setup and handoff. A finished
// result is held in an output register while the next request is accepted.
module rgb_median_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // in_red, in_green, in_blue
  input  logic                         in_tuser,   // op
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,  // med_red, med_green, med_blue, out_row, out_col
  output logic                         out_tlast,
  input  logic                         cfg_we,
  input  logic [rmf_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rmf_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int SIDE  = 2 * MAX_RADIUS + 1;
  localparam int NW    = SIDE * SIDE;
  localparam int NCW   = $clog2(NW + 1);
  localparam int IW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int DEPTH = SIDE * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW0   = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2;
  localparam int PW    = (PW0 > AW + 1) ? PW0 : AW + 1;
  localparam int KS    = PW - AW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int DW    = rmf_pkg::CH_N * rmf_pkg::PIX_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [PW-1:0] SUB0    = PW'(DEPTH) << (KS - 1);

  rmf_pkg::state_t state_r, state_nxt;

  logic [1:0]                radius_r;
  logic [rmf_pkg::CFG_W-1:0] width_r, height_r;
  logic [WW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;
  logic [RDW-1:0]            r_eff;

  logic          op_r;
  logic [DW-1:0] pix_r;
  logic [HW-1:0] in_row_r, nrow_r;
  logic [WW-1:0] in_col_r, ncol_r;
  logic          fdone_r;
  logic [PW-1:0] inpos_r, outpos_r, total_r, lag_r;
  logic [PW-1:0] mod_val_r, sub_r, mod_step;
  logic [AW-1:0] addr_r;
  logic          emit;

  logic [HW:0]   y_r, r0, r1, y1_r;
  logic [WW:0]   x_r, c0, c1, c0_r, c1_r;
  logic [NCW-1:0] n_r;
  logic           rd_v_r;
  logic [IW-1:0]  rd_idx_r;
  logic [DW-1:0]  mem_q_r;
  logic [DW-1:0]  mem [DEPTH];
  logic [DW-1:0]  win_r [NW];

  logic [NW-1:0]          cand_r [rmf_pkg::CH_N];
  logic [NW-1:0]          cand_nxt [rmf_pkg::CH_N];
  logic [NCW-1:0]         k_r [rmf_pkg::CH_N];
  logic [NCW-1:0]         k_nxt [rmf_pkg::CH_N];
  logic [rmf_pkg::PIX_W-1:0] med_r [rmf_pkg::CH_N];
  logic [rmf_pkg::CH_N-1:0]  bit_dec;
  logic [2:0]             b_r;

  logic [rmf_pkg::PIX_W-1:0] out_med_r [rmf_pkg::CH_N];
  logic [9:0]             out_row_r, out_col_r;
  logic                   out_last_r, out_valid_r;
  logic                   load_out, out_last;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
    if (int'(radius_r) > MAX_RADIUS) begin
      r_eff = RDW'(MAX_RADIUS);
    end else begin
      r_eff = RDW'(radius_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rmf_pkg::RADIUS_RST;
      width_r  <= rmf_pkg::WIDTH_RST;
      height_r <= rmf_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rmf_pkg::CFG_RADIUS: radius_r <= cfg_wdata[1:0];
        rmf_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        rmf_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mod_step = (mod_val_r >= sub_r) ? mod_val_r - sub_r : mod_val_r;
  assign emit     = (inpos_r + PW'(1) > outpos_r + lag_r) && (outpos_r < total_r);
  assign out_last = (outpos_r + PW'(1) >= total_r);
  assign load_out = (state_r == rmf_pkg::S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    r0 = ((HW+1)'(nrow_r) > (HW+1)'(r_eff)) ? (HW+1)'(nrow_r) - (HW+1)'(r_eff) : '0;
    r1 = ((HW+1)'(nrow_r) + (HW+1)'(r_eff) < (HW+1)'(h_eff) - (HW+1)'(1)) ?
         (HW+1)'(nrow_r) + (HW+1)'(r_eff) : (HW+1)'(h_eff) - (HW+1)'(1);
    c0 = ((WW+1)'(ncol_r) > (WW+1)'(r_eff)) ? (WW+1)'(ncol_r) - (WW+1)'(r_eff) : '0;
    c1 = ((WW+1)'(ncol_r) + (WW+1)'(r_eff) < (WW+1)'(w_eff) - (WW+1)'(1)) ?
         (WW+1)'(ncol_r) + (WW+1)'(r_eff) : (WW+1)'(w_eff) - (WW+1)'(1);
  end

  always_comb begin
    logic [NW-1:0]  ones;
    logic [NCW-1:0] cnt0;
    for (int c = 0; c < rmf_pkg::CH_N; c++) begin
      for (int i = 0; i < NW; i++) begin
        ones[i] = win_r[i][c*rmf_pkg::PIX_W + int'(b_r)];
      end
      cnt0 = NCW'($countones(cand_r[c] & ~ones));
      if (k_r[c] < cnt0) begin
        bit_dec[c]  = 1'b0;
        cand_nxt[c] = cand_r[c] & ~ones;
        k_nxt[c]    = k_r[c];
      end else begin
        bit_dec[c]  = 1'b1;
        cand_nxt[c] = cand_r[c] & ones;
        k_nxt[c]    = k_r[c] - cnt0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      rmf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = rmf_pkg::S_MUL1;
        end
      end
      rmf_pkg::S_MUL1: state_nxt = rmf_pkg::S_MUL2;
      rmf_pkg::S_MUL2: state_nxt = rmf_pkg::S_DEC;
      rmf_pkg::S_DEC: begin
        if (op_r == rmf_pkg::OP_PIXEL) begin
          state_nxt = fdone_r ? rmf_pkg::S_IDLE : rmf_pkg::S_MODW;
        end else if (!fdone_r || outpos_r >= total_r) begin
          state_nxt = rmf_pkg::S_IDLE;
        end else begin
          state_nxt = rmf_pkg::S_WSET;
        end
      end
      rmf_pkg::S_MODW: begin
        if (sub_r == DEPTH_P) begin
          state_nxt = rmf_pkg::S_WR;
        end
      end
      rmf_pkg::S_WR: state_nxt = emit ? rmf_pkg::S_WSET : rmf_pkg::S_IDLE;
      rmf_pkg::S_WSET: begin
        state_nxt = (r0 > r1 || c0 > c1) ? rmf_pkg::S_MSET : rmf_pkg::S_ROW;
      end
      rmf_pkg::S_ROW: state_nxt = rmf_pkg::S_MODR;
      rmf_pkg::S_MODR: begin
        if (sub_r == DEPTH_P) begin
          state_nxt = rmf_pkg::S_RD;
        end
      end
      rmf_pkg::S_RD: begin
        if (x_r == c1_r) begin
          state_nxt = (y_r == y1_r) ? rmf_pkg::S_WAIT : rmf_pkg::S_ROW;
        end
      end
      rmf_pkg::S_WAIT: state_nxt = rmf_pkg::S_MSET;
      rmf_pkg::S_MSET: state_nxt = rmf_pkg::S_MED;
      rmf_pkg::S_MED: begin
        if (b_r == '0) begin
          state_nxt = rmf_pkg::S_OUT;
        end
      end
      rmf_pkg::S_OUT: begin
        if (load_out) begin
          state_nxt = rmf_pkg::S_IDLE;
        end
      end
      default: state_nxt = rmf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == rmf_pkg::S_WR) begin
      mem[mod_val_r[AW-1:0]] <= pix_r;
    end
    if (state_r == rmf_pkg::S_RD) begin
      mem_q_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    logic [WW:0] cnext;
    if (!rst_n) begin
      in_row_r    <= '0;
      in_col_r    <= '0;
      nrow_r      <= '0;
      ncol_r      <= '0;
      fdone_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
    end else begin
      rd_v_r <= (state_r == rmf_pkg::S_RD);
      if (rd_v_r) begin
        win_r[rd_idx_r] <= mem_q_r;
      end
      unique case (state_r) inside
        rmf_pkg::S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            pix_r   <= in_tdata;
            inpos_r <= PW'(in_row_r) * PW'(w_eff) + PW'(in_col_r);
          end
        end
        rmf_pkg::S_MUL1: outpos_r <= PW'(nrow_r) * PW'(w_eff) + PW'(ncol_r);
        rmf_pkg::S_MUL2: begin
          total_r <= PW'(w_eff) * PW'(h_eff);
          lag_r   <= PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
        end
        rmf_pkg::S_DEC: begin
          mod_val_r <= inpos_r;
          sub_r     <= SUB0;
          if (op_r == rmf_pkg::OP_DRAIN && fdone_r && outpos_r >= total_r) begin
            in_row_r <= '0;
            in_col_r <= '0;
            nrow_r   <= '0;
            ncol_r   <= '0;
            fdone_r  <= 1'b0;
          end
        end
        rmf_pkg::S_MODW, rmf_pkg::S_MODR: begin
          mod_val_r <= mod_step;
          sub_r     <= sub_r >> 1;
          addr_r    <= mod_step[AW-1:0];
        end
        rmf_pkg::S_WR: begin
          cnext = (WW+1)'(in_col_r) + (WW+1)'(1);
          if (cnext >= (WW+1)'(w_eff)) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + HW'(1);
            if ((HW+1)'(in_row_r) + (HW+1)'(1) >= (HW+1)'(h_eff)) begin
              fdone_r <= 1'b1;
            end
          end else begin
            in_col_r <= cnext[WW-1:0];
            if ((HW+1)'(in_row_r) >= (HW+1)'(h_eff)) begin
              fdone_r <= 1'b1;
            end
          end
        end
        rmf_pkg::S_WSET: begin
          y_r  <= r0;
          y1_r <= r1;
          c0_r <= c0;
          c1_r <= c1;
          n_r  <= '0;
        end
        rmf_pkg::S_ROW: begin
          mod_val_r <= PW'(y_r) * PW'(w_eff) + PW'(c0_r);
          sub_r     <= SUB0;
          x_r       <= c0_r;
        end
        rmf_pkg::S_RD: begin
          rd_idx_r <= n_r[IW-1:0];
          n_r      <= n_r + NCW'(1);
          addr_r   <= (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
          if (x_r == c1_r) begin
            y_r <= y_r + (HW+1)'(1);
          end else begin
            x_r <= x_r + (WW+1)'(1);
          end
        end
        rmf_pkg::S_MSET: begin
          for (int c = 0; c < rmf_pkg::CH_N; c++) begin
            for (int i = 0; i < NW; i++) begin
              cand_r[c][i] <= (NCW'(i) < n_r);
            end
            k_r[c] <= n_r >> 1;
          end
          b_r <= 3'd7;
        end
        rmf_pkg::S_MED: begin
          for (int c = 0; c < rmf_pkg::CH_N; c++) begin
            cand_r[c] <= cand_nxt[c];
            k_r[c]    <= k_nxt[c];
            med_r[c]  <= {med_r[c][rmf_pkg::PIX_W-2:0], bit_dec[c]};
          end
          b_r <= b_r - 3'd1;
        end
        default: ;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
        for (int c = 0; c < rmf_pkg::CH_N; c++) begin
          out_med_r[c] <= (n_r == '0) ? '0 : med_r[c];
        end
        out_row_r  <= 10'(nrow_r);
        out_col_r  <= 10'(ncol_r);
        out_last_r <= out_last;
        if (out_last) begin
          in_row_r <= '0;
          in_col_r <= '0;
          nrow_r   <= '0;
          ncol_r   <= '0;
          fdone_r  <= 1'b0;
        end else if ((WW+1)'(ncol_r) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
          ncol_r <= '0;
          nrow_r <= nrow_r + HW'(1);
        end else begin
          ncol_r <= ncol_r + WW'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'd0, out_col_r, out_row_r, out_med_r[2], out_med_r[1], out_med_r[0]};

`ifndef ASSERT_OFF
  a_mod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmf_pkg::S_MODW && sub_r == DEPTH_P) |=> (mod_val_r < DEPTH_P))
    else $error("line store index not reduced below depth");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_last) |=> (nrow_r == '0 && ncol_r == '0 && !fdone_r))
    else $error("frame did not restart after last output");

  a_win_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmf_pkg::S_MED) |-> (int'(n_r) <= NW))
    else $error("window gather overran the window buffer");
`endif

endmodule

// File: bench/rmf_checker.sv
// Checker for the RGB median filter: watches all ports, predicts each result and compares.
module rmf_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [23:0]                 in_tdata,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [47:0]                 out_tdata,
  input  logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [rmf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [rmf_pkg::CFG_W-1:0]   cfg_wdata,
  output int                          errors,
  output int                          pending,
  output int                          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 7168;
  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int MAXR = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } median_t;

  median_t     medians_due[$];
  logic [23:0] pixel_store [STORE_DEPTH];
  logic [1:0]  radius;
  logic [10:0] width_reg, height_reg;
  int          in_row, in_col, out_row, out_col;
  bit          frame_done;

  assign pending = medians_due.size();

  function automatic int clip(int v, int maxv);
    if (v == 0) return 1;
    return v > maxv ? maxv : v;
  endfunction

  function automatic logic [7:0] window_median(int shift, int w, int h, int r);
    int vals[$];
    int r0, r1, c0, c1;
    r0 = out_row > r ? out_row - r : 0;
    r1 = out_row + r < h - 1 ? out_row + r : h - 1;
    c0 = out_col > r ? out_col - r : 0;
    c1 = out_col + r < w - 1 ? out_col + r : w - 1;
    for (int y = r0; y <= r1; y++)
      for (int x = c0; x <= c1; x++)
        vals = {vals, int'((pixel_store[(y * w + x) % STORE_DEPTH] >> shift) & 24'hFF)};
    if (vals.size() == 0) return 8'd0;
    vals.sort();
    return 8'(vals[vals.size() / 2]);
  endfunction

  task automatic restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    frame_done = 0;
  endtask

  task automatic predict_request(logic op, logic [23:0] px);
    int w, h, r, total, lag, outpos, inpos;
    bit emit;
    median_t m;
    w = clip(width_reg, MAXW);
    h = clip(height_reg, MAXH);
    r = radius > MAXR ? MAXR : radius;
    total = w * h;
    lag = r * w + r;
    outpos = out_row * w + out_col;
    emit = 0;
    if (op == rmf_pkg::OP_PIXEL) begin
      if (frame_done) return;
      inpos = in_row * w + in_col;
      pixel_store[inpos % STORE_DEPTH] = px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (in_row >= h) frame_done = 1;
      emit = (inpos + 1 > outpos + lag) && outpos < total;
    end else begin
      if (!frame_done) return;
      if (outpos >= total) begin
        restart_frame();
        return;
      end
      emit = 1;
    end
    if (!emit) return;
    m.red = window_median(0, w, h, r);
    m.green = window_median(8, w, h, r);
    m.blue = window_median(16, w, h, r);
    m.row = out_row[9:0];
    m.col = out_col[9:0];
    m.last = outpos + 1 >= total;
    medians_due = {medians_due, m};
    if (m.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    median_t m;
    if (!rst_n) begin
      errors = 0;
      checked = 0;
      for (int i = 0; i < STORE_DEPTH; i++) pixel_store[i] = '0;
      radius = rmf_pkg::RADIUS_RST;
      width_reg = rmf_pkg::WIDTH_RST;
      height_reg = rmf_pkg::HEIGHT_RST;
      restart_frame();
      medians_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          rmf_pkg::CFG_RADIUS: radius = cfg_wdata[1:0];
          rmf_pkg::CFG_WIDTH:  width_reg = cfg_wdata;
          rmf_pkg::CFG_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (medians_due.size() == 0) begin
          $error("result with no expectation waiting: %h", out_tdata);
          errors++;
        end else begin
          m = medians_due.pop_front();
          checked++;
          compare_field("med_red", m.red, out_tdata[7:0]);
          compare_field("med_green", m.green, out_tdata[15:8]);
          compare_field("med_blue", m.blue, out_tdata[23:16]);
          compare_field("out_row", m.row, out_tdata[33:24]);
          compare_field("out_col", m.col, out_tdata[43:34]);
          compare_field("frame_last", m.last, out_tlast);
        end
      end
    end
  end
endmodule

// File: bench/testbench.sv
// Top of the RGB median filter bench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 600;
  localparam int CW = rmf_pkg::CFG_W;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = rmf_pkg::OP_PIXEL;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic [rmf_pkg::CFG_AW-1:0] cfg_addr = rmf_pkg::CFG_RADIUS;
  logic [rmf_pkg::CFG_W-1:0] cfg_wdata = '0;
  int errors, pending, checked;
  int requests = 0;
  int frames = 0;
  int stall_cycles = 0;
  bit calm = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  rgb_median_filter_unit dut (.*);

  rmf_checker scoreboard (.*);

  always @(negedge clk) out_tready <= calm || ($urandom_range(99) >= 21);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send(logic op, logic [23:0] px);
    while (!calm && $urandom_range(99) < 21) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    requests++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_cfg(int r, int w, int h);
    wait_idle();
    cfg_we <= 1;
    cfg_addr <= rmf_pkg::CFG_RADIUS;
    cfg_wdata <= CW'(r);
    @(negedge clk);
    cfg_addr <= rmf_pkg::CFG_WIDTH;
    cfg_wdata <= CW'(w);
    @(negedge clk);
    cfg_addr <= rmf_pkg::CFG_HEIGHT;
    cfg_wdata <= CW'(h);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [23:0] make_pixel(bit extreme);
    logic [23:0] px;
    int picks[4] = '{0, 255, 1, 128};
    px = 24'($urandom);
    if (extreme)
      for (int c = 0; c < 3; c++) px[c*8 +: 8] = 8'(picks[$urandom_range(3)]);
    return px;
  endfunction

  task automatic run_frame(int r, int w, int h, bit extreme, bit noisy);
    int ew, eh, er, total, lag, drains, stray_at;
    ew = w == 0 ? 1 : (w > 1024 ? 1024 : w);
    eh = h == 0 ? 1 : (h > 1024 ? 1024 : h);
    er = r > 3 ? 3 : r;
    total = ew * eh;
    lag = er * ew + er;
    drains = total < lag ? total : lag;
    stray_at = noisy ? $urandom_range(total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      if (i == stray_at) send(rmf_pkg::OP_DRAIN, make_pixel(0));
      send(rmf_pkg::OP_PIXEL, make_pixel(extreme));
    end
    if (noisy && lag > 0) send(rmf_pkg::OP_PIXEL, make_pixel(0));
    for (int i = 0; i < drains; i++) send(rmf_pkg::OP_DRAIN, make_pixel(0));
    frames++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    set_cfg(0, 0, 0);
    run_frame(0, 0, 0, 1, 0);
    set_cfg(3, 2, 2);
    run_frame(3, 2, 2, 1, 1);
    set_cfg(1, 3, 3);
    run_frame(1, 3, 3, 1, 0);
    set_cfg(2, 4, 1);
    run_frame(2, 4, 1, 1, 1);

    while (requests < 115) begin
      int r, w, h;
      r = $urandom_range(3);
      w = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 10);
      h = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 6);
      set_cfg(r, w, h);
      run_frame(r, w, h, $urandom_range(3) == 0, $urandom_range(3) == 0);
    end

    set_cfg(3, 1, 2047);
    calm = 1;
    run_frame(3, 1, 2047, 1, 0);
    calm = 0;

    wait_idle();
    $display("Covered %0d frames, %0d requests, %0d results checked,", frames, requests,
             checked);
    $display("from single-pixel frames up to a clamped full-height column, radius 0 to 3.");
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
